@@ rtl/prjb_pkg.sv @@
package prjb_pkg;

	localparam int SLOTS       = 32;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_W       = $clog2(SLOTS);
	localparam int OCC_W       = $clog2(SLOTS + 1);
	localparam int SEQ_W       = 32;

	localparam int FRAME_LEN   = 21;
	localparam int MIN_PREFILL = 2;
	localparam int MAX_PREFILL = SLOTS / 2;
	localparam int RECIP_SH    = 20;
	localparam int RECIP       = ((2 ** RECIP_SH) + FRAME_LEN - 1) / FRAME_LEN;
	localparam int TARGET_RST  = 40;

	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_LATE   = 2'd1;
	localparam logic [1:0] ST_DUP    = 2'd2;
	localparam logic [1:0] ST_STALE  = 2'd3;

	localparam logic MODE_INSERT = 1'b0;

	typedef struct packed {
		logic        mode;
		logic [31:0] sequence_req;
		logic [15:0] packet_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  insert_status;
		logic        packet_valid;
		logic [15:0] out_handle;
		logic [31:0] out_sequence;
		logic        lost;
		logic [5:0]  held_count;
	} rsp_t;

	typedef struct packed {
		logic [SEQ_W-1:0]       seq;
		logic [HANDLE_BITS-1:0] handle;
	} slot_ent_t;

	typedef struct packed {
		logic eq;
		logic older;
		logic after;
	} cmp_t;

	// floor(v / FRAME_LEN) by reciprocal, clamped to the prefill range
	function automatic logic [OCC_W-1:0] prefill_of(input logic [15:0] v);
		logic [16+RECIP_SH-1:0] prod;
		logic [15:0]            q;
		logic [OCC_W-1:0]       f;
		prod = (16 + RECIP_SH)'(v) * (16 + RECIP_SH)'(RECIP);
		q    = prod[16+RECIP_SH-1 -: 16];
		if (q < 16'(MIN_PREFILL)) begin
			f = OCC_W'(MIN_PREFILL);
		end else if (q > 16'(MAX_PREFILL)) begin
			f = OCC_W'(MAX_PREFILL);
		end else begin
			f = OCC_W'(q);
		end
		return f;
	endfunction

endpackage

@@ rtl/packet_reorder_jitter_buffer_unit.sv @@
// channel | signals                 | handshake
// --------+-------------------------+----------------------------------
// command | start, busy, req        | beat taken when start && !busy
// result  | done, rsp               | one-cycle strobe, no back-pressure
// config  | cfg_we, cfg_wdata       | written when cfg_we is high
//
// insert: slot read, then late check, then duplicate check and write
// pop: the result comes straight from idle below prefill or when empty; the expected
//   slot is read and checked, and if it does not hold the expected packet the slot table is scanned for a newer one;
//   the single slot read port and the shared sequence comparator set these steps
// asynchronous reset clears valid bits, counters and state; slot table
//   contents stay undefined until written
// results cannot be stalled; busy stays high until the result strobe
module packet_reorder_jitter_buffer_unit
	import prjb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output rsp_t        rsp
);

	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_LATE,
		S_INS_DUP,
		S_POP_CHK,
		S_SCAN
	} state_t;

	state_t                 state_q;
	logic [SEQ_W-1:0]       seq_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [IDX_W-1:0]       idx_q;
	logic [SEQ_W-1:0]       exp_q;
	logic                   started_q;
	logic [OCC_W-1:0]       occ_q;
	logic [OCC_W-1:0]       prefill_q;
	logic [SLOTS-1:0]       vld_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   chk_q;
	logic [IDX_W-1:0]       chk_idx_q;
	rsp_t                   res_q;
	logic                   done_q;

	logic             accept;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic             wr_en;
	slot_ent_t        wr_ent;
	slot_ent_t        rd_ent;
	logic [SEQ_W-1:0] alu_a;
	logic [SEQ_W-1:0] alu_b;
	cmp_t             cmp;
	logic [IDX_W-1:0] req_idx;
	logic [IDX_W-1:0] exp_idx;
	logic             pop_go;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign req_idx = IDX_W'(req.sequence_req % SLOTS);
	assign exp_idx = IDX_W'(exp_q % SLOTS);
	assign pop_go  = started_q || (occ_q >= prefill_q);

	// shared comparator operand select
	always_comb begin
		alu_a = rd_ent.seq;
		alu_b = exp_q;
		case (state_q)
			S_INS_LATE: begin
				alu_a = seq_q;
				alu_b = exp_q;
			end
			S_INS_DUP: begin
				alu_a = rd_ent.seq;
				alu_b = seq_q;
			end
			default: begin
				alu_a = rd_ent.seq;
				alu_b = exp_q;
			end
		endcase
	end

	prjb_seq_cmp u_cmp (
		.a   (alu_a),
		.b   (alu_b),
		.res (cmp)
	);

	always_comb begin
		rd_en  = 1'b0;
		rd_idx = req_idx;
		if (state_q == S_IDLE) begin
			rd_en  = accept;
			rd_idx = (req.mode == MODE_INSERT) ? req_idx : exp_idx;
		end else if (state_q == S_SCAN) begin
			rd_en  = (cnt_q < CNT_W'(SLOTS));
			rd_idx = cnt_q[IDX_W-1:0];
		end
	end

	assign wr_en         = (state_q == S_INS_DUP) && !(vld_q[idx_q] && cmp.eq);
	assign wr_ent.seq    = seq_q;
	assign wr_ent.handle = hnd_q;

	prjb_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (idx_q),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefill_q <= prefill_of(16'(TARGET_RST));
		end else if (cfg_we) begin
			prefill_q <= prefill_of(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			seq_q     <= '0;
			hnd_q     <= '0;
			idx_q     <= '0;
			exp_q     <= '0;
			started_q <= 1'b0;
			occ_q     <= '0;
			vld_q     <= '0;
			cnt_q     <= '0;
			chk_q     <= 1'b0;
			chk_idx_q <= '0;
			res_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q     <= '0;
						seq_q     <= req.sequence_req;
						hnd_q     <= HANDLE_BITS'(req.packet_handle);
						if (req.mode == MODE_INSERT) begin
							idx_q <= req_idx;
							if (!started_q && occ_q == '0) begin
								exp_q <= req.sequence_req;
							end
							state_q <= S_INS_LATE;
						end else begin
							idx_q <= exp_idx;
							if (!started_q && pop_go) begin
								started_q <= 1'b1;
							end
							if (pop_go && occ_q != '0) begin
								state_q <= S_POP_CHK;
							end else begin
								done_q <= 1'b1;
							end
						end
					end
				end
				S_INS_LATE: begin
					if (started_q && cmp.older) begin
						res_q.insert_status <= ST_LATE;
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						state_q <= S_INS_DUP;
					end
				end
				S_INS_DUP: begin
					if (vld_q[idx_q] && cmp.eq) begin
						res_q.insert_status <= ST_DUP;
					end else if (vld_q[idx_q]) begin
						res_q.insert_status <= ST_STALE;
					end else begin
						res_q.insert_status <= ST_STORED;
						vld_q[idx_q]        <= 1'b1;
						occ_q               <= occ_q + OCC_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_POP_CHK: begin
					if (vld_q[idx_q] && cmp.eq) begin
						vld_q[idx_q]       <= 1'b0;
						occ_q              <= occ_q - OCC_W'(1);
						res_q.packet_valid <= 1'b1;
						res_q.out_handle   <= 16'(rd_ent.handle);
						res_q.out_sequence <= exp_q;
						exp_q              <= exp_q + SEQ_W'(1);
						done_q             <= 1'b1;
						state_q            <= S_IDLE;
					end else begin
						cnt_q   <= '0;
						chk_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					chk_q     <= (cnt_q < CNT_W'(SLOTS));
					chk_idx_q <= cnt_q[IDX_W-1:0];
					cnt_q     <= cnt_q + CNT_W'(1);
					if (chk_q && vld_q[chk_idx_q] && cmp.after) begin
						exp_q      <= exp_q + SEQ_W'(1);
						res_q.lost <= 1'b1;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (cnt_q == CNT_W'(SLOTS)) begin
						// last slot checked, nothing newer held
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;

	always_comb begin
		rsp            = res_q;
		rsp.held_count = 6'(occ_q);
	end

`ifndef SYNTH
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_insert_multicycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.mode == MODE_INSERT) |=> (busy && !done))
		else $error("insert finished without slot check");

	a_deliver_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.packet_valid) |-> (!rsp.lost && rsp.insert_status == ST_STORED))
		else $error("delivered beat carries loss or insert status");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.held_count <= 6'(SLOTS)))
		else $error("held count above slot count");
`endif

endmodule

@@ rtl/prjb_seq_cmp.sv @@
module prjb_seq_cmp
	import prjb_pkg::*;
(
	input  logic [SEQ_W-1:0] a,
	input  logic [SEQ_W-1:0] b,
	output cmp_t             res
);

	logic [SEQ_W-1:0] d;

	// wrapped signed difference
	assign d         = a - b;
	assign res.eq    = (d == '0);
	assign res.older = d[SEQ_W-1];
	assign res.after = (d != '0) && !d[SEQ_W-1];

endmodule

@@ rtl/prjb_slot_mem.sv @@
module prjb_slot_mem
	import prjb_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  slot_ent_t        wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output slot_ent_t        rd_data
);

	slot_ent_t mem [SLOTS];
	slot_ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_q;

endmodule

@@ tb/tb_packet_reorder_jitter_buffer_unit.sv @@
module tb_packet_reorder_jitter_buffer_unit;
	import prjb_pkg::*;

	localparam logic MODE_POP = ~MODE_INSERT;
	localparam int PHASE_OPS = 135;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        done;
	rsp_t        rsp;

	class playout_scoreboard;
		bit          slot_full [SLOTS];
		logic [31:0] slot_seq [SLOTS];
		logic [15:0] slot_hnd [SLOTS];
		logic [31:0] next_play;
		bit          playing;
		int unsigned held;
		logic [15:0] delay_ms;
		rsp_t        pending_results [$];
		int          errors;

		function new();
			foreach (slot_full[i]) begin
				slot_full[i] = 1'b0;
			end
			next_play = '0;
			playing   = 1'b0;
			held      = 0;
			delay_ms  = 16'(TARGET_RST);
			errors    = 0;
		endfunction

		function bit is_older(logic [31:0] a, logic [31:0] b);
			logic [31:0] d;
			d = a - b;
			return d[31];
		endfunction

		function bit is_newer(logic [31:0] a, logic [31:0] b);
			logic [31:0] d;
			d = a - b;
			return (d != 0) && !d[31];
		endfunction

		function int unsigned prefill_frames();
			int unsigned f;
			f = delay_ms / FRAME_LEN;
			if (f < MIN_PREFILL) begin
				f = MIN_PREFILL;
			end
			if (f > MAX_PREFILL) begin
				f = MAX_PREFILL;
			end
			return f;
		endfunction

		function void note_request(req_t r);
			rsp_t             e;
			logic [IDX_W-1:0] idx;
			logic [31:0]      s;
			bit               go;
			e = '0;
			if (r.mode == MODE_INSERT) begin
				s   = r.sequence_req;
				idx = IDX_W'(s % SLOTS);
				if (!playing && held == 0) begin
					next_play = s;
				end
				if (playing && is_older(s, next_play)) begin
					e.insert_status = ST_LATE;
				end else if (slot_full[idx] && slot_seq[idx] == s) begin
					e.insert_status = ST_DUP;
				end else begin
					if (slot_full[idx]) begin
						e.insert_status = ST_STALE;
					end else begin
						e.insert_status = ST_STORED;
						held++;
					end
					slot_full[idx] = 1'b1;
					slot_seq[idx]  = s;
					slot_hnd[idx]  = r.packet_handle;
				end
			end else begin
				go = 1'b1;
				if (!playing) begin
					if (held < prefill_frames()) begin
						go = 1'b0;
					end else begin
						playing = 1'b1;
					end
				end
				if (go && held != 0) begin
					idx = IDX_W'(next_play % SLOTS);
					if (slot_full[idx] && slot_seq[idx] == next_play) begin
						slot_full[idx] = 1'b0;
						held--;
						e.packet_valid = 1'b1;
						e.out_handle   = slot_hnd[idx];
						e.out_sequence = next_play;
						next_play++;
					end else begin
						foreach (slot_full[i]) begin
							if (!e.lost && slot_full[i] && is_newer(slot_seq[i], next_play)) begin
								next_play++;
								e.lost = 1'b1;
							end
						end
					end
				end
			end
			e.held_count = 6'(held);
			pending_results.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (pending_results.size() == 0) begin
				$display("%0t result with nothing pending: actual %h", $time, a);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			compare_field("insert_status", 32'(e.insert_status), 32'(a.insert_status));
			compare_field("packet_valid", 32'(e.packet_valid), 32'(a.packet_valid));
			compare_field("out_handle", 32'(e.out_handle), 32'(a.out_handle));
			compare_field("out_sequence", e.out_sequence, a.out_sequence);
			compare_field("lost", 32'(e.lost), 32'(a.lost));
			compare_field("held_count", 32'(e.held_count), 32'(a.held_count));
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	playout_scoreboard sb = new();

	packet_reorder_jitter_buffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_result(rsp);
			end
			if (start && !busy) begin
				sb.note_request(req);
			end
			if (cfg_we) begin
				sb.delay_ms = cfg_wdata;
			end
		end
	end

	function automatic req_t insert_op(logic [31:0] s, logic [15:0] h);
		req_t r;
		r.mode          = MODE_INSERT;
		r.sequence_req  = s;
		r.packet_handle = h;
		return r;
	endfunction

	function automatic req_t pop_op();
		req_t r;
		r.mode          = MODE_POP;
		r.sequence_req  = $urandom;
		r.packet_handle = 16'($urandom);
		return r;
	endfunction

	task automatic send_op(req_t r, bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_delay(logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(bit gaps);
		logic [31:0]        stream_pos;
		logic signed [31:0] lag;
		int unsigned        pick;
		req_t               r;
		stream_pos = sb.next_play;
		repeat (PHASE_OPS) begin
			lag = stream_pos - sb.next_play;
			if (lag < 0) begin
				stream_pos = sb.next_play;
				lag = 0;
			end
			pick = $urandom_range(0, 99);
			if (lag > 20 || pick < 42) begin
				r = pop_op();
			end else if (pick < 80) begin
				r = insert_op(stream_pos + $urandom_range(0, 4), 16'($urandom));
				stream_pos += 1;
				if ($urandom_range(0, 9) == 0) begin
					stream_pos += $urandom_range(1, 3);
				end
			end else if (pick < 86) begin
				r = insert_op(stream_pos - $urandom_range(0, 10), 16'($urandom));
			end else if (pick < 92) begin
				r = insert_op(stream_pos + SLOTS * $urandom_range(1, 3) + $urandom_range(0, 3),
					16'($urandom));
			end else begin
				r = insert_op($urandom, 16'($urandom));
			end
			send_op(r, gaps);
		end
	endtask

	initial begin
		logic [15:0] phase_delay [7];
		phase_delay = '{16'd0, 16'd65535, 16'd40, 16'd357, 16'd336, 16'd42, 16'd0};
		phase_delay[6] = 16'($urandom);
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// prefill of three frames
		write_delay(16'd63);
		send_op(pop_op(), 1'b0);
		send_op(insert_op(32'hFFFF_FFFE, 16'h0000), 1'b0);
		send_op(pop_op(), 1'b0);
		send_op(insert_op(32'hFFFF_FFFF, 16'hFFFF), 1'b0);
		send_op(insert_op(32'hFFFF_FFFF, 16'h1234), 1'b0);
		// older than the anchor but taken before playout
		send_op(insert_op(32'hFFFF_FFFD, 16'h5A5A), 1'b0);
		send_op(insert_op(32'h0000_0001, 16'hA5A5), 1'b0);
		send_op(pop_op(), 1'b0);
		send_op(pop_op(), 1'b0);
		send_op(insert_op(32'hFFFF_FFF0, 16'h0F0F), 1'b0);
		send_op(pop_op(), 1'b0);
		send_op(pop_op(), 1'b0);
		// only an older packet held
		send_op(pop_op(), 1'b0);
		send_op(insert_op(32'h0000_0022, 16'h3C3C), 1'b0);
		send_op(insert_op(32'h0000_0002, 16'hC3C3), 1'b0);
		send_op(pop_op(), 1'b0);
		send_op(insert_op(32'h0000_001D, 16'h7777), 1'b0);
		send_op(insert_op(32'h0000_0003, 16'h8888), 1'b0);
		send_op(pop_op(), 1'b0);
		send_op(pop_op(), 1'b0);

		foreach (phase_delay[p]) begin
			drain();
			write_delay(phase_delay[p]);
			run_phase(p != 6 && $urandom_range(0, 3) != 0);
		end

		drain();
		repeat (SLOTS + 8) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/prjb_pkg.sv
rtl/prjb_seq_cmp.sv
rtl/prjb_slot_mem.sv
rtl/packet_reorder_jitter_buffer_unit.sv
tb/tb_packet_reorder_jitter_buffer_unit.sv
